@@ rtl/cam_generation_trigger_macros.svh @@
// Assertion macros used by the CAM generation trigger top level.
`ifndef CAM_GENERATION_TRIGGER_MACROS_SVH
`define CAM_GENERATION_TRIGGER_MACROS_SVH

// Checks that post holds in the same cycle whenever pre holds.
`define CGT_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that post holds in the cycle after pre holds.
`define CGT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/cgt_pkg.sv @@
// Types, constants and helper functions of the CAM generation trigger.
package cgt_pkg;

    localparam int unsigned D2_W = 49;

    // Reactive DCC busy-ratio bands (thresholds in 1/1000, intervals in ms).
    localparam logic [9:0]  BUSY_TH_1 = 10'd300;
    localparam logic [9:0]  BUSY_TH_2 = 10'd400;
    localparam logic [9:0]  BUSY_TH_3 = 10'd500;
    localparam logic [9:0]  BUSY_TH_4 = 10'd650;
    localparam logic [15:0] BAND_MS_0 = 16'd100;
    localparam logic [15:0] BAND_MS_1 = 16'd200;
    localparam logic [15:0] BAND_MS_2 = 16'd400;
    localparam logic [15:0] BAND_MS_3 = 16'd500;
    localparam logic [15:0] BAND_MS_4 = 16'd1000;

    localparam logic [31:0] VAM_TIMEOUT_MS = 32'd5000;
    localparam logic [11:0] HEADING_HALF   = 12'd1800;
    localparam logic [11:0] HEADING_FULL   = 12'd3600;
    localparam logic [15:0] MAX_INT_RESET  = 16'd1000;
    localparam logic [31:0] LIM_SQ_RESET   = 32'd1600;

    typedef enum logic [2:0] {
        CAUSE_NONE  = 3'd0,
        CAUSE_FIRST = 3'd1,
        CAUSE_DYN   = 3'd2,
        CAUSE_REP   = 3'd3,
        CAUSE_MAX   = 3'd4
    } cause_t;

    typedef enum logic [2:0] {
        REG_MIN_INT  = 3'd0,
        REG_MAX_INT  = 3'd1,
        REG_REPEAT   = 3'd2,
        REG_HEADING  = 3'd3,
        REG_DISTANCE = 3'd4,
        REG_SPEED    = 3'd5,
        REG_DCC      = 3'd6,
        REG_VRU      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] min_interval_ms;
        logic [15:0] max_interval_ms;
        logic [3:0]  repeat_count;
        logic [10:0] heading_limit;
        logic [15:0] distance_limit;
        logic [13:0] speed_limit;
        logic        dcc_enable;
        logic        vru_mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        min_interval_ms: 16'd100,
        max_interval_ms: MAX_INT_RESET,
        repeat_count:    4'd3,
        heading_limit:   11'd40,
        distance_limit:  16'd40,
        speed_limit:     14'd50,
        dcc_enable:      1'b1,
        vru_mode:        1'b0
    };

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [13:0]        speed;
        logic [11:0]        heading;
        logic [9:0]         busy_ratio;
    } tick_t;

    // Item in the decision stage with both candidate squared distances.
    typedef struct packed {
        tick_t           tick;
        logic [D2_W-1:0] d2_state;
        logic [D2_W-1:0] d2_prev;
        logic            use_prev;
    } stage_t;

    // Feedback from the decision stage to the front stage.
    typedef struct packed {
        logic               adv;
        logic               send;
        logic signed [23:0] last_x;
        logic signed [23:0] last_y;
    } back_t;

    typedef struct packed {
        logic        send;
        logic        msg_kind;
        cause_t      cause;
        logic [15:0] gate_interval_ms;
    } result_t;

    // Band interval for a busy ratio.
    function automatic logic [15:0] dcc_band(input logic [9:0] busy);
        logic [15:0] band;
        if (busy < BUSY_TH_1) band = BAND_MS_0;
        else if (busy < BUSY_TH_2) band = BAND_MS_1;
        else if (busy < BUSY_TH_3) band = BAND_MS_2;
        else if (busy < BUSY_TH_4) band = BAND_MS_3;
        else band = BAND_MS_4;
        return band;
    endfunction

    // Squared distance between two points; each axis difference fits 24 bits.
    function automatic logic [D2_W-1:0] dist_sq(
        input logic signed [23:0] x,
        input logic signed [23:0] y,
        input logic signed [23:0] lx,
        input logic signed [23:0] ly
    );
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [24:0]        ax;
        logic [24:0]        ay;
        logic [47:0]        sx;
        logic [47:0]        sy;
        dx = {x[23], x} - {lx[23], lx};
        dy = {y[23], y} - {ly[23], ly};
        ax = dx[24] ? -dx : dx;
        ay = dy[24] ? -dy : dy;
        sx = 48'(ax[23:0]) * 48'(ax[23:0]);
        sy = 48'(ay[23:0]) * 48'(ay[23:0]);
        return {1'b0, sx} + {1'b0, sy};
    endfunction

endpackage

@@ rtl/cgt_tick_if.sv @@
// Channel that carries one check tick item.
interface cgt_tick_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [13:0]        speed;
    logic [11:0]        heading;
    logic [9:0]         busy_ratio;

    modport source (
        output valid, now_ms, pos_x, pos_y, speed, heading, busy_ratio,
        input  ready
    );
    modport sink (
        input  valid, now_ms, pos_x, pos_y, speed, heading, busy_ratio,
        output ready
    );
endinterface

@@ rtl/cgt_result_if.sv @@
// Channel that carries one generation decision item.
interface cgt_result_if;
    logic        valid;
    logic        ready;
    logic        send;
    logic        msg_kind;
    logic [2:0]  cause;
    logic [15:0] gate_interval_ms;

    modport source (
        output valid, send, msg_kind, cause, gate_interval_ms,
        input  ready
    );
    modport sink (
        input  valid, send, msg_kind, cause, gate_interval_ms,
        output ready
    );
endinterface

@@ rtl/cam_generation_trigger.sv @@
// Top level of the CAM / VAM generation trigger with reactive DCC gating.
//
// Usage:
//   tick carries one check tick per item: time, true position, speed, heading
//   and channel busy ratio. decision returns exactly one item per tick: the
//   send flag, the message kind, the cause and the minimum interval in force.
//   Registers are written through wr_en / wr_index / wr_data while no tick is
//   in flight; a write takes effect at the next clock edge.
// Pipeline: input register, distance register and result register in turn.
//   One tick per cycle is sustained while decision.ready is high; the sender
//   state is updated in the decision stage in the same cycle, and the squared
//   distances are formed one stage ahead against both the stored position and
//   the position of the item in front.
// Reset:
//   Registers take their default values, the sender state is cleared and the
//   pipeline is empty.
// Stalls:
//   While decision.ready is low the result is held; up to three items are
//   buffered inside and tick.ready then drops.
module cam_generation_trigger import cgt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    cgt_tick_if.sink     tick,
    cgt_result_if.source decision,
    input  logic         wr_en,
    input  logic [2:0]   wr_index,
    input  logic [15:0]  wr_data
);

    `include "cam_generation_trigger_macros.svh"

    cfg_t        cfg_reg;
    logic [31:0] lim_sq_reg;
    tick_t       tick_data;
    stage_t      s2_item;
    logic        s2_valid;
    back_t       fb;
    result_t     res;
    logic        res_valid;

    // Configuration registers; the squared distance limit is kept alongside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg    <= CFG_RESET;
            lim_sq_reg <= LIM_SQ_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_MIN_INT:  cfg_reg.min_interval_ms <= wr_data;
                REG_MAX_INT:  cfg_reg.max_interval_ms <= wr_data;
                REG_REPEAT:   cfg_reg.repeat_count    <= wr_data[3:0];
                REG_HEADING:  cfg_reg.heading_limit   <= wr_data[10:0];
                REG_DISTANCE:
                begin
                    cfg_reg.distance_limit <= wr_data;
                    lim_sq_reg             <= 32'(wr_data) * 32'(wr_data);
                end
                REG_SPEED:    cfg_reg.speed_limit     <= wr_data[13:0];
                REG_DCC:      cfg_reg.dcc_enable      <= wr_data[0];
                REG_VRU:      cfg_reg.vru_mode        <= wr_data[0];
            endcase
        end
    end

    assign tick_data = '{
        now_ms:     tick.now_ms,
        pos_x:      tick.pos_x,
        pos_y:      tick.pos_y,
        speed:      tick.speed,
        heading:    tick.heading,
        busy_ratio: tick.busy_ratio
    };

    // Input register and distance stage.
    cgt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_data  (tick_data),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .fb         (fb),
        .s2_item    (s2_item),
        .s2_valid   (s2_valid)
    );

    // Decision stage and result register.
    cgt_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .lim_sq    (lim_sq_reg),
        .s2_item   (s2_item),
        .s2_valid  (s2_valid),
        .out_ready (decision.ready),
        .fb        (fb),
        .res       (res),
        .res_valid (res_valid)
    );

    assign decision.valid            = res_valid;
    assign decision.send             = res.send;
    assign decision.msg_kind         = res.msg_kind;
    assign decision.cause            = res.cause;
    assign decision.gate_interval_ms = res.gate_interval_ms;

    // A result sends exactly when it carries a cause.
    `CGT_ASSERT_NOW(a_send_cause, decision.valid,
                    decision.send == (decision.cause != CAUSE_NONE),
                    "send flag disagrees with cause")

    // The message kind follows the mode register.
    `CGT_ASSERT_NOW(a_kind_mode, decision.valid,
                    decision.msg_kind == cfg_reg.vru_mode,
                    "message kind disagrees with mode")

    // A result taken with nothing behind it leaves the output empty.
    `CGT_ASSERT_NEXT(a_drain, decision.valid && decision.ready && !fb.adv,
                     !decision.valid, "result register did not drain")

endmodule

@@ rtl/cgt_front.sv @@
// Input register and squared-distance stage of the CAM generation trigger.
module cgt_front import cgt_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  tick_t  tick_data,
    input  logic   tick_valid,
    output logic   tick_ready,
    input  back_t  fb,
    output stage_t s2_item,
    output logic   s2_valid
);

    logic   s1_valid_reg;
    logic   s1_valid_next;
    tick_t  s1_reg;
    logic   s2_valid_reg;
    logic   s2_valid_next;
    stage_t s2_reg;
    logic   s1_adv;
    logic   take;
    logic [D2_W-1:0] d2_state;
    logic [D2_W-1:0] d2_prev;

    // The input register moves on when the decision stage is free or draining.
    assign s1_adv     = s1_valid_reg && (!s2_valid_reg || fb.adv);
    assign tick_ready = !s1_valid_reg || s1_adv;
    assign take       = tick_valid && tick_ready;

    // Distance against the stored position, and against the item now being
    // decided in case that item turns out to send.
    assign d2_state = dist_sq(s1_reg.pos_x, s1_reg.pos_y, fb.last_x, fb.last_y);
    assign d2_prev  = dist_sq(s1_reg.pos_x, s1_reg.pos_y,
                              s2_reg.tick.pos_x, s2_reg.tick.pos_y);

    // Valid flags of both stages.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
            s2_valid_next = 1'b1;
        else if (fb.adv)
            s2_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
            s1_reg <= tick_data;
        if (s1_adv)
        begin
            s2_reg.tick     <= s1_reg;
            s2_reg.d2_state <= d2_state;
            s2_reg.d2_prev  <= d2_prev;
            s2_reg.use_prev <= s2_valid_reg && fb.send;
        end
    end

    assign s2_item  = s2_reg;
    assign s2_valid = s2_valid_reg;

endmodule

@@ rtl/cgt_decide.sv @@
// Decision stage: trigger rules, sender state and the result register.
module cgt_decide import cgt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic [31:0] lim_sq,
    input  stage_t      s2_item,
    input  logic        s2_valid,
    input  logic        out_ready,
    output back_t       fb,
    output result_t     res,
    output logic        res_valid
);

    logic [31:0]        last_time_reg;
    logic signed [23:0] last_x_reg;
    logic signed [23:0] last_y_reg;
    logic [13:0]        last_speed_reg;
    logic [11:0]        last_heading_reg;
    logic [15:0]        cur_int_reg;
    logic [15:0]        cur_int_next;
    logic [3:0]         rep_reg;
    logic [3:0]         rep_next;
    logic               first_reg;
    result_t            out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               adv;
    logic [15:0]        band;
    logic [15:0]        gate;
    logic [31:0]        elapsed;
    logic [11:0]        hd;
    logic               head_moved;
    logic [13:0]        sd;
    logic               speed_moved;
    logic [D2_W-1:0]    d2;
    logic               dist_moved;
    logic [15:0]        gate_ci;
    logic [15:0]        gate_mx;
    cause_t             cause;
    tick_t              t;

    assign t   = s2_item.tick;
    assign adv = s2_valid && (!out_valid_reg || out_ready);

    // Minimum interval: the configured one, raised to the reactive DCC band when DCC is on.
    assign band = dcc_band(t.busy_ratio);
    always_comb
    begin
        if (!cfg.dcc_enable)
            gate = cfg.min_interval_ms;
        else
            gate = (band > cfg.min_interval_ms) ? band : cfg.min_interval_ms;
    end

    assign elapsed = t.now_ms - last_time_reg;

    // Heading change, taken the short way round the circle.
    assign hd = (t.heading > last_heading_reg) ? t.heading - last_heading_reg
                                               : last_heading_reg - t.heading;
    always_comb
    begin
        if (hd > HEADING_HALF)
            head_moved = (hd < HEADING_FULL) &&
                         ((HEADING_FULL - hd) > {1'b0, cfg.heading_limit});
        else
            head_moved = hd > {1'b0, cfg.heading_limit};
    end

    assign sd = (t.speed > last_speed_reg) ? t.speed - last_speed_reg
                                           : last_speed_reg - t.speed;
    assign speed_moved = sd > cfg.speed_limit;

    // Pick the distance that matches the position now on record.
    assign d2 = s2_item.use_prev ? s2_item.d2_prev : s2_item.d2_state;
    assign dist_moved = d2 > {{(D2_W - 32){1'b0}}, lim_sq};

    assign gate_ci = (cur_int_reg > gate) ? cur_int_reg : gate;
    assign gate_mx = (cfg.max_interval_ms > gate) ? cfg.max_interval_ms : gate;

    // Generation rules, in priority order.
    always_comb
    begin
        cause        = CAUSE_NONE;
        cur_int_next = cur_int_reg;
        rep_next     = rep_reg;
        if (!cfg.vru_mode)
        begin
            priority if (!first_reg)
                cause = CAUSE_FIRST;
            else if (elapsed >= {16'd0, gate})
            begin
                priority if (head_moved || dist_moved || speed_moved)
                begin
                    cause        = CAUSE_DYN;
                    rep_next     = 4'd0;
                    cur_int_next = (elapsed < {16'd0, cfg.max_interval_ms})
                                   ? elapsed[15:0] : cfg.max_interval_ms;
                end
                else if ((elapsed >= {16'd0, gate_ci}) && (rep_reg < cfg.repeat_count))
                begin
                    cause    = CAUSE_REP;
                    rep_next = rep_reg + 4'd1;
                end
                else if (elapsed >= {16'd0, gate_mx})
                begin
                    cause        = CAUSE_MAX;
                    cur_int_next = cfg.max_interval_ms;
                end
                else
                    cause = CAUSE_NONE;
            end
            else
                cause = CAUSE_NONE;
        end
        else
        begin
            priority if (!first_reg)
                cause = CAUSE_FIRST;
            else if (elapsed >= VAM_TIMEOUT_MS)
                cause = CAUSE_MAX;
            else if ((elapsed >= {16'd0, gate}) && (dist_moved || head_moved))
                cause = CAUSE_DYN;
            else
                cause = CAUSE_NONE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Sender state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg    <= '0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            last_speed_reg   <= '0;
            last_heading_reg <= '0;
            cur_int_reg      <= MAX_INT_RESET;
            rep_reg          <= '0;
            first_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                cur_int_reg <= cur_int_next;
                rep_reg     <= rep_next;
                if (cause != CAUSE_NONE)
                begin
                    last_time_reg    <= t.now_ms;
                    last_x_reg       <= t.pos_x;
                    last_y_reg       <= t.pos_y;
                    last_speed_reg   <= t.speed;
                    last_heading_reg <= t.heading;
                    first_reg        <= 1'b1;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.send             <= (cause != CAUSE_NONE);
            out_reg.msg_kind         <= cfg.vru_mode;
            out_reg.cause            <= cause;
            out_reg.gate_interval_ms <= gate;
        end
    end

    assign fb.adv    = adv;
    assign fb.send   = (cause != CAUSE_NONE);
    assign fb.last_x = last_x_reg;
    assign fb.last_y = last_y_reg;

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

endmodule

@@ tb/sv/cam_generation_trigger_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the CAM / VAM generation trigger: predictor, scoreboard, stimulus.
module cam_generation_trigger_tb import cgt_pkg::*; ;

    localparam int          CYCLE_LIMIT     = 500000;
    localparam int          RANDOM_PER_PASS = 141;
    localparam int          VAM_PASS        = 3;
    localparam logic [31:0] VAM_QUIET_MS    = 32'd5000;

    // Tracks the sender state of the block and checks every decision item.
    class decision_scoreboard;
        cfg_t               cfg;
        logic [31:0]        last_time;
        logic signed [23:0] last_x;
        logic signed [23:0] last_y;
        logic [13:0]        last_speed;
        logic [11:0]        last_heading;
        logic [15:0]        interval_now;
        logic [3:0]         repeats;
        logic               sent_once;
        result_t            pending[$];
        int                 errors;
        int                 checked;
        int                 ticks;
        int                 per_cause[5];

        function new();
            cfg.min_interval_ms = 16'd100;
            cfg.max_interval_ms = 16'd1000;
            cfg.repeat_count    = 4'd3;
            cfg.heading_limit   = 11'd40;
            cfg.distance_limit  = 16'd40;
            cfg.speed_limit     = 14'd50;
            cfg.dcc_enable      = 1'b1;
            cfg.vru_mode        = 1'b0;
            last_time    = '0;
            last_x       = '0;
            last_y       = '0;
            last_speed   = '0;
            last_heading = '0;
            interval_now = 16'd1000;
            repeats      = '0;
            sent_once    = 1'b0;
            errors       = 0;
            checked      = 0;
            ticks        = 0;
            foreach (per_cause[i]) per_cause[i] = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [15:0] v);
            case (idx)
                REG_MIN_INT:  cfg.min_interval_ms = v;
                REG_MAX_INT:  cfg.max_interval_ms = v;
                REG_REPEAT:   cfg.repeat_count    = v[3:0];
                REG_HEADING:  cfg.heading_limit   = v[10:0];
                REG_DISTANCE: cfg.distance_limit  = v;
                REG_SPEED:    cfg.speed_limit     = v[13:0];
                REG_DCC:      cfg.dcc_enable      = v[0];
                REG_VRU:      cfg.vru_mode        = v[0];
                default:      ;
            endcase
        endfunction

        // Works out the send decision for one tick and updates the sender state.
        function result_t decide_send(tick_t t);
            result_t     r;
            logic [15:0] band;
            logic [15:0] gate;
            logic [15:0] rep_gate;
            logic [15:0] max_gate;
            logic [31:0] elapsed;
            longint      dx;
            longint      dy;
            longint      d2;
            longint      lim2;
            int          hd;
            int          sd;
            bit          head_moved;
            bit          dist_moved;
            bit          speed_moved;
            cause_t      why;

            // Reactive DCC raises the minimum interval with the busy ratio.
            if (t.busy_ratio < 10'd300)      band = 16'd100;
            else if (t.busy_ratio < 10'd400) band = 16'd200;
            else if (t.busy_ratio < 10'd500) band = 16'd400;
            else if (t.busy_ratio < 10'd650) band = 16'd500;
            else                             band = 16'd1000;
            if (!cfg.dcc_enable)
                gate = cfg.min_interval_ms;
            else
                gate = (cfg.min_interval_ms > band) ? cfg.min_interval_ms : band;
            elapsed = t.now_ms - last_time;

            // Heading change folds around the full circle; odd headings may go negative.
            hd = int'(t.heading) - int'(last_heading);
            if (hd < 0)
                hd = -hd;
            if (hd > 1800)
                hd = 3600 - hd;
            head_moved = hd > int'(cfg.heading_limit);

            // Distance is compared squared, so no root is needed.
            dx = longint'($signed(t.pos_x)) - longint'(last_x);
            dy = longint'($signed(t.pos_y)) - longint'(last_y);
            d2 = dx * dx + dy * dy;
            lim2 = longint'(cfg.distance_limit) * longint'(cfg.distance_limit);
            dist_moved = d2 > lim2;

            sd = int'(t.speed) - int'(last_speed);
            if (sd < 0)
                sd = -sd;
            speed_moved = sd > int'(cfg.speed_limit);

            rep_gate = (interval_now > gate) ? interval_now : gate;
            max_gate = (cfg.max_interval_ms > gate) ? cfg.max_interval_ms : gate;
            why = CAUSE_NONE;
            if (!cfg.vru_mode) begin
                if (!sent_once) begin
                    why = CAUSE_FIRST;
                end
                else if (elapsed >= 32'(gate)) begin
                    if (head_moved || dist_moved || speed_moved) begin
                        interval_now = (elapsed < 32'(cfg.max_interval_ms)) ?
                                       elapsed[15:0] : cfg.max_interval_ms;
                        repeats = '0;
                        why = CAUSE_DYN;
                    end
                    else if (elapsed >= 32'(rep_gate) && repeats < cfg.repeat_count) begin
                        repeats = repeats + 4'd1;
                        why = CAUSE_REP;
                    end
                    else if (elapsed >= 32'(max_gate)) begin
                        interval_now = cfg.max_interval_ms;
                        why = CAUSE_MAX;
                    end
                end
            end
            else begin
                // VAM rules: no speed trigger and no repeats.
                if (!sent_once)
                    why = CAUSE_FIRST;
                else if (elapsed >= VAM_QUIET_MS)
                    why = CAUSE_MAX;
                else if (elapsed >= 32'(gate) && (dist_moved || head_moved))
                    why = CAUSE_DYN;
            end

            if (why != CAUSE_NONE) begin
                last_time    = t.now_ms;
                last_x       = t.pos_x;
                last_y       = t.pos_y;
                last_speed   = t.speed;
                last_heading = t.heading;
                sent_once    = 1'b1;
            end

            r.send             = (why != CAUSE_NONE);
            r.msg_kind         = cfg.vru_mode;
            r.cause            = why;
            r.gate_interval_ms = gate;
            return r;
        endfunction

        function void note_tick(tick_t t);
            ticks++;
            pending.push_back(decide_send(t));
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Compares one decision item with the oldest expected decision.
        task check_decision(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                report_mismatch("decision item with no tick outstanding");
                return;
            end
            want = pending[0];
            pending.delete(0);
            checked++;
            per_cause[int'(want.cause)]++;
            if (got.send !== want.send)
                report_mismatch($sformatf("decision %0d send %b, expected %b",
                                          checked, got.send, want.send));
            if (got.msg_kind !== want.msg_kind)
                report_mismatch($sformatf("decision %0d msg_kind %b, expected %b",
                                          checked, got.msg_kind, want.msg_kind));
            if (got.cause !== want.cause)
                report_mismatch($sformatf("decision %0d cause %0d, expected %0d",
                                          checked, got.cause, want.cause));
            if (got.gate_interval_ms !== want.gate_interval_ms)
                report_mismatch($sformatf("decision %0d gate %0d, expected %0d",
                                          checked, got.gate_interval_ms,
                                          want.gate_interval_ms));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [15:0] wr_data;
    int          cycles = 0;
    int unsigned send_burst = 0;
    int unsigned take_burst = 0;

    // Stimulus cursor: the last tick offered, from which the next one evolves.
    logic [31:0]        cur_now = '0;
    logic signed [23:0] cur_x   = '0;
    logic signed [23:0] cur_y   = '0;
    logic [13:0]        cur_spd = '0;
    logic [11:0]        cur_hdg = '0;

    decision_scoreboard sb = new();

    cgt_tick_if   tick_ch();
    cgt_result_if decision_ch();

    cam_generation_trigger i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick_ch),
        .decision (decision_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #10 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Idle length for one item; now and then a burst of back-to-back items.
    function automatic int unsigned draw_wait(inout int unsigned burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic tick_t mk(logic [31:0] now, int x, int y, int s, int h, int b);
        tick_t t;
        t.now_ms     = now;
        t.pos_x      = 24'(x);
        t.pos_y      = 24'(y);
        t.speed      = 14'(s);
        t.heading    = 12'(h);
        t.busy_ratio = 10'(b);
        return t;
    endfunction

    // Next random tick: mostly a plausible track around the limits, some noise.
    function automatic tick_t next_tick();
        tick_t       t;
        int unsigned roll;
        int unsigned scale;
        int unsigned r;
        int          d;
        int          v;
        roll = $urandom_range(0, 99);
        if (sb.cfg.vru_mode)
            scale = 6000;
        else begin
            scale = 1000;
            if (32'(sb.cfg.max_interval_ms) > scale) scale = 32'(sb.cfg.max_interval_ms);
            if (32'(sb.cfg.min_interval_ms) > scale) scale = 32'(sb.cfg.min_interval_ms);
        end
        if (roll < 3)
            t.now_ms = cur_now + $urandom;
        else
            t.now_ms = cur_now + $urandom_range(0, (roll < 65) ? scale / 3 : scale + scale / 2);
        t.busy_ratio = 10'($urandom_range(0, 1023));
        if (roll >= 94) begin
            t.pos_x   = 24'($urandom);
            t.pos_y   = 24'($urandom);
            t.speed   = 14'($urandom);
            t.heading = 12'($urandom);
            return t;
        end
        r = 32'(sb.cfg.distance_limit);
        r = ($urandom_range(0, 3) == 0) ? 2 * r + 2 : r / 2 + 1;
        d = int'($urandom_range(0, 2 * r)) - int'(r);
        t.pos_x = 24'(int'(cur_x) + d);
        d = int'($urandom_range(0, 2 * r)) - int'(r);
        t.pos_y = 24'(int'(cur_y) + d);
        r = 32'(sb.cfg.speed_limit);
        r = ($urandom_range(0, 3) == 0) ? 2 * r + 2 : r / 2 + 1;
        v = int'(cur_spd) + int'($urandom_range(0, 2 * r)) - int'(r);
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
        t.speed = 14'(v);
        r = 32'(sb.cfg.heading_limit);
        r = ($urandom_range(0, 3) == 0) ? 2 * r + 2 : r / 2 + 1;
        v = int'(cur_hdg) + int'($urandom_range(0, 2 * r)) - int'(r);
        v = ((v % 3600) + 3600) % 3600;
        t.heading = 12'(v);
        return t;
    endfunction

    // Offers one tick, waits for it to be taken, then idles for a random gap.
    task automatic push_tick(input tick_t t);
        int unsigned gap;
        tick_ch.valid      <= 1'b1;
        tick_ch.now_ms     <= t.now_ms;
        tick_ch.pos_x      <= t.pos_x;
        tick_ch.pos_y      <= t.pos_y;
        tick_ch.speed      <= t.speed;
        tick_ch.heading    <= t.heading;
        tick_ch.busy_ratio <= t.busy_ratio;
        @(posedge clk);
        while (tick_ch.ready !== 1'b1) @(posedge clk);
        sb.note_tick(t);
        cur_now = t.now_ms;
        cur_x   = t.pos_x;
        cur_y   = t.pos_y;
        cur_spd = t.speed;
        cur_hdg = t.heading;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender off until every expected decision has come back.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(REG_MIN_INT,  c.min_interval_ms);
        write_reg(REG_MAX_INT,  c.max_interval_ms);
        write_reg(REG_REPEAT,   16'(c.repeat_count));
        write_reg(REG_HEADING,  16'(c.heading_limit));
        write_reg(REG_DISTANCE, c.distance_limit);
        write_reg(REG_SPEED,    16'(c.speed_limit));
        write_reg(REG_DCC,      16'(c.dcc_enable));
        write_reg(REG_VRU,      16'(c.vru_mode));
        wr_en <= 1'b0;
    endtask

    // Decision side: random stalls, one check per accepted item.
    initial
    begin
        result_t     got;
        int unsigned stall;
        decision_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = draw_wait(take_burst);
            if (stall > 0) begin
                decision_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            decision_ch.ready <= 1'b1;
            @(posedge clk);
            while (decision_ch.valid !== 1'b1) @(posedge clk);
            got.send             = decision_ch.send;
            got.msg_kind         = decision_ch.msg_kind;
            got.cause            = cause_t'(decision_ch.cause);
            got.gate_interval_ms = decision_ch.gate_interval_ms;
            sb.check_decision(got);
        end
    end

    // Main sequence: reset, directed ticks, then random passes over several settings.
    initial
    begin
        cfg_t  passes[$];
        cfg_t  c;
        tick_t directed[$];

        rst_n              <= 1'b0;
        wr_en              <= 1'b0;
        wr_index           <= REG_MIN_INT;
        wr_data            <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.now_ms     <= '0;
        tick_ch.pos_x      <= '0;
        tick_ch.pos_y      <= '0;
        tick_ch.speed      <= '0;
        tick_ch.heading    <= '0;
        tick_ch.busy_ratio <= '0;

        // Register settings: defaults, both extremes, VAM variants, random ones.
        c = sb.cfg;
        passes.push_back(c);
        c = '0;
        passes.push_back(c);
        c.min_interval_ms = 16'hFFFF;
        c.max_interval_ms = 16'hFFFF;
        c.repeat_count    = 4'hF;
        c.heading_limit   = 11'd1800;
        c.distance_limit  = 16'hFFFF;
        c.speed_limit     = 14'd16383;
        c.dcc_enable      = 1'b1;
        passes.push_back(c);
        c = passes[0];
        c.vru_mode = 1'b1;
        passes.push_back(c);
        c = '0;
        c.vru_mode = 1'b1;
        passes.push_back(c);
        c = passes[2];
        c.vru_mode = 1'b1;
        passes.push_back(c);
        repeat (4) begin
            c.min_interval_ms = 16'($urandom_range(0, 2000));
            c.max_interval_ms = 16'($urandom_range(0, 3000));
            c.repeat_count    = 4'($urandom_range(0, 15));
            c.heading_limit   = 11'($urandom_range(0, 1800));
            c.distance_limit  = 16'($urandom_range(0, 2000));
            c.speed_limit     = 14'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                                : $urandom_range(0, 500));
            c.dcc_enable      = 1'($urandom_range(0, 1));
            c.vru_mode        = ($urandom_range(0, 3) == 0);
            passes.push_back(c);
        end
        passes.push_back(passes[0]);

        // Directed CAM ticks under the reset settings: first send, heading
        // trigger, repeats then the quiet spell up to the max interval, speed past
        // the limit, distance at and past it, every busy band, heading wrap at north,
        // an out-of-range heading, position and speed extremes, time wrap.
        directed.push_back(mk(32'd0,    0,  0, 0,  0,    0));
        directed.push_back(mk(32'd50,   0,  0, 0,  0,    0));
        directed.push_back(mk(32'd150,  0,  0, 0,  41,   0));
        directed.push_back(mk(32'd300,  0,  0, 0,  41,   299));
        directed.push_back(mk(32'd450,  0,  0, 0,  41,   299));
        directed.push_back(mk(32'd600,  0,  0, 0,  41,   299));
        directed.push_back(mk(32'd750,  0,  0, 0,  41,   299));
        directed.push_back(mk(32'd1600, 0,  0, 0,  41,   299));
        directed.push_back(mk(32'd1800, 0,  0, 51, 41,   300));
        directed.push_back(mk(32'd2200, 40, 0, 51, 41,   399));
        directed.push_back(mk(32'd2700, 81, 0, 51, 41,   400));
        directed.push_back(mk(32'd3300, 81, 0, 51, 41,   499));
        directed.push_back(mk(32'd4000, 81, 0, 51, 3599, 500));
        directed.push_back(mk(32'd5000, 81, 0, 51, 0,    649));
        directed.push_back(mk(32'd6500, 81, 0, 51, 4095, 650));
        directed.push_back(mk(32'hFFFF_FF00, -8388608, 8388607, 16383, 1800, 1023));
        directed.push_back(mk(32'h0000_0010, 8388607, -8388608, 0, 0, 1000));
        directed.push_back(mk(32'h0000_0500, 8388607, -8388608, 0, 2047, 0));
        directed.push_back(mk(32'h8000_0000, 0, 0, 8191, 3600, 512));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < passes.size(); p++) begin
            if (p > 0) begin
                drain();
                repeat (4) @(posedge clk);
                write_config(passes[p]);
            end
            if (p == 0) begin
                foreach (directed[i])
                    push_tick(directed[i]);
            end
            if (p == VAM_PASS) begin
                // VAM: quiet timeout, a move past the gate, one inside it, a turn.
                push_tick(mk(cur_now + 32'd5000, cur_x, cur_y, cur_spd, cur_hdg, 0));
                push_tick(mk(cur_now + 32'd100, int'(cur_x) + 100, cur_y, cur_spd,
                             cur_hdg, 0));
                push_tick(mk(cur_now + 32'd50, int'(cur_x) + 200, cur_y, cur_spd,
                             cur_hdg, 0));
                push_tick(mk(cur_now + 32'd2000, cur_x, cur_y, cur_spd,
                             (int'(cur_hdg) + 100) % 3600, 700));
            end
            for (int i = 0; i < RANDOM_PER_PASS; i++) begin
                push_tick(next_tick());
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("%0d ticks over %0d register settings, %0d decisions checked, %0d mismatches",
                 sb.ticks, passes.size(), sb.checked, sb.errors);
        $display("decisions by cause: none %0d, first %0d, dynamics %0d, repeat %0d, max %0d",
                 sb.per_cause[0], sb.per_cause[1], sb.per_cause[2], sb.per_cause[3],
                 sb.per_cause[4]);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ cam_generation_trigger.f @@
+incdir+rtl
rtl/cgt_pkg.sv
rtl/cgt_tick_if.sv
rtl/cgt_result_if.sv
rtl/cgt_front.sv
rtl/cgt_decide.sv
rtl/cam_generation_trigger.sv
tb/sv/cam_generation_trigger_tb.sv
